/* hw/rtl/cubic_soft_clip_distortion_macros.svh */
// ---------------------------------------------------------------------------
// Cubic soft clip distortion: assertion macros
// Implication checks that compile away when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef CUBIC_SOFT_CLIP_DISTORTION_MACROS_SVH
`define CUBIC_SOFT_CLIP_DISTORTION_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while in reset
`define CSCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while in reset
`define CSCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CSCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CSCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* hw/rtl/cscd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Cubic soft clip distortion: shared package
// Word widths, fixed-point formats and register codes.
// ---------------------------------------------------------------------------
package cscd_pkg;

  // Sample format and full-scale magnitude
  localparam int SAMPLE_W   = 16;
  localparam int FULL_SCALE = 32767;
  localparam int FS_W       = $clog2(FULL_SCALE + 1);
  localparam int MAG_W      = SAMPLE_W;

  // Configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_W-1:0] DRIVE_RESET = CFG_W'(4096);
  localparam logic [CFG_W-1:0] MIX_RESET   = CFG_W'(32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRIVE_GAIN = 1'b0,
    CFG_MIX_AMOUNT = 1'b1
  } cscd_cfg_t;

  // Fixed-point formats: shaped values in Q.30, drive in Q4.12, mix in Q0.16
  localparam int FRAC_Q     = 30;
  localparam int C_W        = FRAC_Q + 1;
  localparam int ONE_Q      = 1 << FRAC_Q;
  localparam int DRIVE_FRAC = 12;
  localparam int MIX_FRAC   = 16;
  localparam int MIX_ONE    = 1 << MIX_FRAC;

  // Gain product and clip threshold
  localparam int P_W      = MAG_W + CFG_W;
  localparam int CLIP_LIM = FULL_SCALE << DRIVE_FRAC;
  localparam int PD_W     = $clog2(CLIP_LIM);
  localparam int AP_W     = DRIVE_FRAC;

  // Integer part of the dry magnitude over full scale
  localparam int AD_W = $clog2(((1 << (SAMPLE_W - 1)) / FULL_SCALE) + 1);
  localparam int X_W  = AD_W + FRAC_Q;

  // Side information that travels with each word
  typedef struct packed {
    logic neg;
    logic last;
  } cscd_side_t;

endpackage
`default_nettype wire

/* hw/rtl/cscd_cdiv.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Constant divider by full scale
// Three-stage quotient and remainder of (num << SH) / FULL_SCALE by
// reciprocal multiply, back multiply and a single correction step.
// ---------------------------------------------------------------------------
module cscd_cdiv
  import cscd_pkg::*;
#(
  parameter int N_W = FS_W,
  parameter int SH  = FRAC_Q,
  parameter int Q_W = FRAC_Q
) (
  input  logic             clk,
  input  logic [N_W-1:0]   num,
  output logic [Q_W-1:0]   quo,
  output logic [FS_W-1:0]  rem
);

  localparam int K    = N_W + SH;
  localparam int R_W  = K - FS_W + 2;
  localparam int PR_W = N_W + R_W;
  localparam int EF_W = Q_W + FS_W;
  localparam int D_W  = FS_W + 1;
  localparam logic [63:0]    RECIP_WIDE = (64'd1 << K) / 64'(FULL_SCALE);
  localparam logic [R_W-1:0] RECIP      = RECIP_WIDE[R_W-1:0];
  localparam logic [D_W-1:0] DIVISOR    = D_W'(FULL_SCALE);

  logic [PR_W-1:0] prod_r;
  logic [N_W-1:0]  num_a_r;
  logic [Q_W-1:0]  est;
  logic [EF_W-1:0] ef_r;
  logic [Q_W-1:0]  est_r;
  logic [N_W-1:0]  num_b_r;
  logic [K-1:0]    nsh;
  logic [D_W-1:0]  rdiff;
  logic            fix;
  logic [Q_W-1:0]  quo_r;
  logic [FS_W-1:0] rem_r;
  logic [Q_W-1:0]  quo_nxt;
  logic [FS_W-1:0] rem_nxt;

  // Estimate is the true quotient or one below it
  assign est = prod_r[N_W +: Q_W];

  // Remainder is below twice the divisor, so its low bits suffice
  always_comb begin
    nsh     = K'(num_b_r) << SH;
    rdiff   = nsh[D_W-1:0] - ef_r[D_W-1:0];
    fix     = (rdiff >= DIVISOR);
    quo_nxt = est_r + Q_W'(fix);
    rem_nxt = fix ? FS_W'(rdiff - DIVISOR) : rdiff[FS_W-1:0];
  end

  // Advance reciprocal, back-multiply and correction stages
  always_ff @(posedge clk) begin
    prod_r  <= num * RECIP;
    num_a_r <= num;
    ef_r    <= est * EF_W'(FULL_SCALE);
    est_r   <= est;
    num_b_r <= num_a_r;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
  end

  assign quo = quo_r;
  assign rem = rem_r;

endmodule
`default_nettype wire

/* hw/rtl/cubic_soft_clip_distortion.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "cubic_soft_clip_distortion_macros.svh"
// ---------------------------------------------------------------------------
// Cubic soft clip distortion
// Drive gain, hard clip, cubic soft clip 1.5c - 0.5c^3, dry/wet mix and
// saturation on a stream of signed samples, one word per clock while not busy.
//
//   channel  direction  handshake             payload
//   cfg      in         cfg_we                cfg_index, cfg_wdata
//   in       in         start && !busy        in_sample_in, in_last_in
//   out      out        out_strobe            out_sample_out, out_last_out
//
// A word is taken on every clock with start high and busy low. The 18 stages
// are the magnitude, the gain product, two full-scale dividers of three stages
// each in series per path, the clip, square, cube and soft clip registers, the
// mix multipliers, the sum, scale, saturation, rescale and output registers.
// Reset empties the pipeline, sets drive to 1.0 and mix to 0.5, and holds
// busy high until the first clock after reset is released.
// Results are shown for one clock each; nothing in the pipe ever waits.
// ---------------------------------------------------------------------------
module cubic_soft_clip_distortion
  import cscd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic                       in_last_in,
  output logic                       out_strobe,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic                       out_last_out
);

  localparam int LAT   = 18;
  localparam int W_W   = C_W + 1;
  localparam int PW_W  = CFG_W + 1 + W_W;
  localparam int MXD_W = MIX_FRAC + 2 + W_W;
  localparam int SUM_W = MXD_W + 1;
  localparam int M_W   = FRAC_Q + 2;
  localparam int O_W   = M_W + FS_W + 1;
  localparam logic [C_W-1:0]             C_ONE   = C_W'(ONE_Q);
  localparam logic signed [M_W-1:0]      M_MAX   = M_W'(ONE_Q);
  localparam logic signed [M_W-1:0]      M_MIN   = -M_MAX;
  localparam logic signed [SAMPLE_W-1:0] OUT_MAX = SAMPLE_W'(FULL_SCALE);
  localparam logic signed [SAMPLE_W-1:0] OUT_MIN = -OUT_MAX;

  // Configuration and control
  logic             busy_r;
  logic [CFG_W-1:0] drive_gain_r;
  logic [CFG_W-1:0] mix_amount_r;
  logic             accept;
  logic [LAT-1:1]   v_r;
  cscd_side_t       side_r [1:LAT-1];

  // Front end: magnitude, gain product and dividers
  logic [MAG_W-1:0]  mag1_nxt;
  logic [MAG_W-1:0]  mag1_r;
  logic [P_W-1:0]    p2_r;
  logic [5:0]        clip_sr_r;
  logic [AD_W-1:0]   ad4;
  logic [FS_W-1:0]   rd4;
  logic [AP_W-1:0]   ap5;
  logic [FS_W-1:0]   rp5;
  logic [FRAC_Q-1:0] fd7;
  logic [FS_W-1:0]   rfd7;
  logic [FRAC_Q-1:0] fp8;
  logic [FS_W-1:0]   rfp8;
  logic [AD_W-1:0]   ad_sr_r [3];
  logic [AP_W-1:0]   ap_sr_r [3];
  logic [X_W-1:0]    x_sr_r  [4];

  // Shaper
  logic [C_W-1:0]   c9_r;
  logic [2*C_W-1:0] sq10;
  logic [C_W-1:0]   c2_10_r;
  logic [C_W-1:0]   c10_r;
  logic [2*C_W-1:0] cu11;
  logic [C_W-1:0]   c3_11_r;
  logic [C_W-1:0]   c11_r;
  logic [C_W+1:0]   tri12;
  logic [C_W-1:0]   y12;
  logic signed [W_W-1:0] wet12_nxt;
  logic signed [W_W-1:0] dry12_nxt;
  logic signed [W_W-1:0] wet12_r;
  logic signed [W_W-1:0] dry12_r;

  // Mix, saturate and rescale
  logic [MIX_FRAC:0]           dmix;
  logic signed [PW_W-1:0]      pw13_r;
  logic signed [MXD_W-1:0]     pd13_r;
  logic signed [SUM_W-1:0]     sum14_r;
  logic signed [SUM_W-1:0]     sbias;
  logic signed [SUM_W-1:0]     sadj;
  logic signed [M_W-1:0]       m15_r;
  logic signed [M_W-1:0]       ms16_nxt;
  logic signed [M_W-1:0]       ms16_r;
  logic signed [O_W-1:0]       o17_r;
  logic signed [O_W-1:0]       obias;
  logic signed [O_W-1:0]       oadj;
  logic signed [SAMPLE_W-1:0]  out_sample_nxt;
  logic                        out_strobe_r;
  logic signed [SAMPLE_W-1:0]  out_sample_r;
  logic                        out_last_r;

  assign accept = start & ~busy_r;

  // Hold busy through reset and the first clock after it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Write configuration registers; drop unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_gain_r <= DRIVE_RESET;
      mix_amount_r <= MIX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DRIVE_GAIN: drive_gain_r <= cfg_wdata;
        CFG_MIX_AMOUNT: mix_amount_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance valid bits with the words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r          <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      v_r          <= {v_r[LAT-2:1], accept};
      out_strobe_r <= v_r[LAT-1];
    end
  end

  // Magnitude of the incoming sample; the most negative one maps to 2^15
  assign mag1_nxt = in_sample_in[SAMPLE_W-1] ? (~$unsigned(in_sample_in) + MAG_W'(1))
                                             : $unsigned(in_sample_in);

  // Dry path: mag = ad * FS + rd, then x = ad.frac(rd / FS) in Q.30
  cscd_cdiv #(.N_W(MAG_W), .SH(0), .Q_W(AD_W)) u_div_mag (
    .clk (clk),
    .num (mag1_r),
    .quo (ad4),
    .rem (rd4)
  );

  cscd_cdiv #(.N_W(FS_W), .SH(FRAC_Q), .Q_W(FRAC_Q)) u_frac_dry (
    .clk (clk),
    .num (rd4),
    .quo (fd7),
    .rem (rfd7)
  );

  // Wet path: gain product p = ap * FS + rp, then c = ap.frac(rp / FS) scaled by 2^-12, in Q.30
  cscd_cdiv #(.N_W(PD_W), .SH(0), .Q_W(AP_W)) u_div_gain (
    .clk (clk),
    .num (p2_r[PD_W-1:0]),
    .quo (ap5),
    .rem (rp5)
  );

  cscd_cdiv #(.N_W(FS_W), .SH(FRAC_Q), .Q_W(FRAC_Q)) u_frac_wet (
    .clk (clk),
    .num (rp5),
    .quo (fp8),
    .rem (rfp8)
  );

  // Square and cube of the clipped value
  assign sq10 = c9_r * c9_r;
  assign cu11 = c2_10_r * c10_r;

  // Soft clip (3c - c^3) / 2 and sign restore on both paths
  always_comb begin
    tri12     = {1'b0, c11_r, 1'b0} + (C_W+2)'(c11_r) - (C_W+2)'(c3_11_r);
    y12       = tri12[C_W:1];
    wet12_nxt = side_r[11].neg ? -$signed({1'b0, y12}) : $signed({1'b0, y12});
    dry12_nxt = side_r[11].neg ? -$signed({1'b0, x_sr_r[3]})
                               : $signed({1'b0, x_sr_r[3]});
  end

  // Dry weight is one minus the wet fraction
  assign dmix = (MIX_FRAC+1)'(MIX_ONE) - {1'b0, mix_amount_r};

  // Divide the mix sum by 2^16 toward zero, then saturate to +/-1.0
  always_comb begin
    sbias = sum14_r[SUM_W-1] ? SUM_W'(MIX_ONE - 1) : '0;
    sadj  = sum14_r + sbias;
    if (m15_r > M_MAX) begin
      ms16_nxt = M_MAX;
    end else if (m15_r < M_MIN) begin
      ms16_nxt = M_MIN;
    end else begin
      ms16_nxt = m15_r;
    end
  end

  // Rescale to a sample, truncating toward zero
  always_comb begin
    obias          = o17_r[O_W-1] ? O_W'(ONE_Q - 1) : '0;
    oadj           = o17_r + obias;
    out_sample_nxt = SAMPLE_W'(oadj >>> FRAC_Q);
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    side_r[1] <= '{neg: in_sample_in[SAMPLE_W-1], last: in_last_in};
    for (int i = 2; i < LAT; i++) begin
      side_r[i] <= side_r[i-1];
    end
    mag1_r    <= mag1_nxt;
    p2_r      <= mag1_r * drive_gain_r;
    clip_sr_r <= {clip_sr_r[4:0], (p2_r >= P_W'(CLIP_LIM))};

    ad_sr_r[0] <= ad4;
    ap_sr_r[0] <= ap5;
    for (int i = 1; i < 3; i++) begin
      ad_sr_r[i] <= ad_sr_r[i-1];
      ap_sr_r[i] <= ap_sr_r[i-1];
    end
    x_sr_r[0] <= {ad_sr_r[2], fd7};
    for (int i = 1; i < 4; i++) begin
      x_sr_r[i] <= x_sr_r[i-1];
    end

    c9_r    <= clip_sr_r[5] ? C_ONE
                            : {1'b0, ap_sr_r[2], fp8[FRAC_Q-1:DRIVE_FRAC]};
    c2_10_r <= sq10[FRAC_Q +: C_W];
    c10_r   <= c9_r;
    c3_11_r <= cu11[FRAC_Q +: C_W];
    c11_r   <= c10_r;
    wet12_r <= wet12_nxt;
    dry12_r <= dry12_nxt;

    pw13_r  <= $signed({1'b0, mix_amount_r}) * wet12_r;
    pd13_r  <= $signed({1'b0, dmix}) * dry12_r;
    sum14_r <= SUM_W'(pw13_r) + SUM_W'(pd13_r);
    m15_r   <= M_W'(sadj >>> MIX_FRAC);
    ms16_r  <= ms16_nxt;
    o17_r   <= ms16_r * $signed({1'b0, FS_W'(FULL_SCALE)});

    out_sample_r <= out_sample_nxt;
    out_last_r   <= side_r[LAT-1].last;
  end

  assign busy           = busy_r;
  assign out_strobe     = out_strobe_r;
  assign out_sample_out = out_sample_r;
  assign out_last_out   = out_last_r;

  // Checks
  `CSCD_ASSERT_IMP(a_out_latency, clk, rst_n, out_strobe, $past(start && !busy, LAT), "result without a word taken 18 clocks earlier")
  `CSCD_ASSERT_IMP(a_out_range, clk, rst_n, out_strobe, (out_sample_out <= OUT_MAX) && (out_sample_out >= OUT_MIN), "output beyond full scale")
  `CSCD_ASSERT_IMP(a_clip_bound, clk, rst_n, v_r[9], c9_r <= C_ONE, "clipped value above 1.0")
  `CSCD_ASSERT_IMP(a_mix_sat, clk, rst_n, v_r[16], (ms16_r <= M_MAX) && (ms16_r >= M_MIN), "mix not saturated")
  `CSCD_ASSERT_IMP(a_frac_rem, clk, rst_n, v_r[7] || v_r[8], (!v_r[7] || (rfd7 < FS_W'(FULL_SCALE))) && (!v_r[8] || (rfp8 < FS_W'(FULL_SCALE))), "fraction remainder not below full scale")
  `CSCD_ASSERT_NXT(a_busy_low, clk, rst_n, !busy, !busy, "busy rose outside reset")

endmodule
`default_nettype wire
